// ----- design/sdts_pkg.sv -----
// Shared types and constants for the signed decimal token summer.
package sdts_pkg;

	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharCr    = 8'h0D;

	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	typedef enum logic [1:0] {
		PH_GAP  = 2'd0,
		PH_NUM  = 2'd1,
		PH_JUNK = 2'd2
	} sdts_phase_t;

	// classified text word
	typedef struct packed {
		logic       ws;
		logic       minus;
		logic       digit;
		logic [3:0] dval;
		logic       last;
	} sdts_word_t;

	typedef struct packed {
		logic           push;
		logic           pop;
		logic           full;
		logic [QAw:0]   count;
	} sdts_q_st_t;

	typedef struct packed {
		logic vld_s1;
		logic last_s1;
	} sdts_back_st_t;

endpackage

// ----- design/sdts_byte_if.sv -----
// Text byte channel: valid/ready handshake carrying one byte and the chunk end mark.
interface sdts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       chunk_end;

	modport source (output valid, output text_byte, output chunk_end, input ready);
	modport sink (input valid, input text_byte, input chunk_end, output ready);
endinterface

// ----- design/sdts_sum_if.sv -----
// Sum channel: valid/ready handshake carrying one signed 64-bit chunk total.
interface sdts_sum_if;
	logic               valid;
	logic               ready;
	logic signed [63:0] chunk_sum;

	modport source (output valid, output chunk_sum, input ready);
	modport sink (input valid, input chunk_sum, output ready);
endinterface

// ----- design/signed_decimal_token_summer.sv -----
// Top level of the signed decimal token summer.
// Usage:
//   text: one byte word per handshake; chunk_end marks the last byte of a chunk.
//   sum:  one signed 64-bit word per chunk, the wrapped sum of all decimal tokens
//         (optional leading minus, leading digits count, trailing junk ignored).
// Throughput: one byte per cycle sustained; the front classifies each byte and
//   pushes it into a four-word queue, the back scans one queued word per cycle.
// Path: the last byte of a chunk is written into the queue, read and scanned into
//   the commit stage, then accumulated into the output register that drives sum.
// Back-pressure: while a sum waits unaccepted the back holds; the queue keeps
//   taking bytes until it is full, then text.ready drops.
// Reset: arst_n clears the queue, scanner state, running total and sum valid;
//   the block takes bytes from the first cycle after reset is released.
module signed_decimal_token_summer import sdts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sdts_byte_if.sink  text,
	sdts_sum_if.source sum
);

	sdts_word_t    f_word, q_word;
	logic          push, pop, q_empty;
	sdts_q_st_t    q_st;
	sdts_back_st_t b_st;

	sdts_front u_front (
		.text   (text),
		.q_full (q_st.full),
		.push   (push),
		.word   (f_word)
	);

	sdts_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (f_word),
		.pop    (pop),
		.rdata  (q_word),
		.empty  (q_empty),
		.st     (q_st)
	);

	sdts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.word    (q_word),
		.pop     (pop),
		.sum     (sum),
		.st      (b_st)
	);

	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.count <= (QAw+1)'(QDepth))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.pop |-> (q_st.count != '0))
		else $error("pop from empty queue");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_st.push |-> !q_st.full)
		else $error("push into full queue");

	a_sum_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sum.valid) |-> $past(b_st.last_s1))
		else $error("sum raised without a chunk end in the back");

endmodule

// ----- design/sdts_front.sv -----
// Front end: accepts text words and classifies each byte.
module sdts_front import sdts_pkg::*; (
	sdts_byte_if.sink text,
	input  logic       q_full,
	output logic       push,
	output sdts_word_t word
);

	logic [7:0] b;

	assign b = text.text_byte;
	assign text.ready = !q_full;
	assign push = text.valid && !q_full;

	always_comb begin
		word.ws    = (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
		word.minus = (b == CharMinus);
		word.digit = (b >= CharZero) && (b <= CharNine);
		word.dval  = 4'(b - CharZero);
		word.last  = text.chunk_end;
	end

endmodule

// ----- design/sdts_queue.sv -----
// Short FIFO of classified words between front and back.
module sdts_queue import sdts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sdts_word_t wdata,
	input  logic       pop,
	output sdts_word_t rdata,
	output logic       empty,
	output sdts_q_st_t st
);

	sdts_word_t mem_q [QDepth];
	logic [QAw-1:0] wr_q, rd_q;
	logic [QAw:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_comb begin
		st.push  = push;
		st.pop   = pop;
		st.full  = (cnt_q == (QAw+1)'(QDepth));
		st.count = cnt_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- design/sdts_back.sv -----
// Back end: token scanner, accumulator and output register.
module sdts_back import sdts_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  sdts_word_t    word,
	output logic          pop,
	sdts_sum_if.source    sum,
	output sdts_back_st_t st
);

	sdts_phase_t phase_q, phase_d;
	logic        minus_q, minus_d;
	logic        digit_q, digit_d;
	logic [63:0] val_q, val_d;

	logic        vld_s1, last_s1, add_s1, neg_s1;
	logic [63:0] tok_s1;
	logic        c_add, c_neg;
	logic [63:0] c_tok;
	logic        ws_commit;

	logic [63:0] total_q, sum_q, addend, total_d;
	logic        out_vld_q;
	logic        en;

	assign en  = !out_vld_q || sum.ready;
	assign pop = en && !q_empty;

	assign sum.valid     = out_vld_q;
	assign sum.chunk_sum = sum_q;

	always_comb begin
		st.vld_s1  = vld_s1;
		st.last_s1 = vld_s1 && last_s1;
	end

	always_comb begin
		phase_d   = phase_q;
		minus_d   = minus_q;
		digit_d   = digit_q;
		val_d     = val_q;
		ws_commit = 1'b0;
		case (phase_q)
			PH_GAP: begin
				if (!word.ws) begin
					if (word.minus) begin
						minus_d = 1'b1;
						phase_d = PH_NUM;
					end else if (word.digit) begin
						val_d   = 64'(word.dval);
						digit_d = 1'b1;
						phase_d = PH_NUM;
					end else begin
						phase_d = PH_JUNK;
					end
				end
			end
			PH_NUM: begin
				if (word.digit) begin
					val_d   = (val_q << 3) + (val_q << 1) + 64'(word.dval);
					digit_d = 1'b1;
				end else if (word.ws) begin
					ws_commit = 1'b1;
				end else begin
					phase_d = PH_JUNK;
				end
			end
			default: begin
				if (word.ws) begin
					ws_commit = 1'b1;
				end
			end
		endcase

		c_add = 1'b0;
		c_neg = minus_q;
		c_tok = val_q;
		if (ws_commit) begin
			c_add   = digit_q;
			phase_d = PH_GAP;
			minus_d = 1'b0;
			digit_d = 1'b0;
			val_d   = '0;
		end else if (word.last) begin
			c_add = digit_d;
			c_neg = minus_d;
			c_tok = val_d;
		end
		if (word.last) begin
			phase_d = PH_GAP;
			minus_d = 1'b0;
			digit_d = 1'b0;
			val_d   = '0;
		end
	end

	// scanner state and commit stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_GAP;
			minus_q <= 1'b0;
			digit_q <= 1'b0;
			val_q   <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			add_s1  <= 1'b0;
		end else if (en) begin
			vld_s1 <= pop;
			if (pop) begin
				phase_q <= phase_d;
				minus_q <= minus_d;
				digit_q <= digit_d;
				val_q   <= val_d;
				last_s1 <= word.last;
				add_s1  <= c_add;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && pop) begin
			neg_s1 <= c_neg;
			tok_s1 <= c_tok;
		end
	end

	// negation folded in as invert plus carry-in
	assign addend  = add_s1 ? (tok_s1 ^ {64{neg_s1}}) : '0;
	assign total_d = total_q + addend + 64'(add_s1 && neg_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (en && vld_s1 && last_s1) begin
				out_vld_q <= 1'b1;
			end else if (sum.ready) begin
				out_vld_q <= 1'b0;
			end
			if (en && vld_s1) begin
				if (last_s1) begin
					total_q <= '0;
				end else begin
					total_q <= total_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s1 && last_s1) begin
			sum_q <= total_d;
		end
	end

endmodule
